>>> hw/rtl/column_standard_scaler_assert.svh
// ----------------------------------------------------------------------------
// column_standard_scaler_assert.svh
// Assertion macros for the scaler checker.
// ----------------------------------------------------------------------------
`ifndef COLUMN_STANDARD_SCALER_ASSERT_SVH
`define COLUMN_STANDARD_SCALER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("column_standard_scaler assertion failed");

// next-cycle implication
`define CSS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("column_standard_scaler assertion failed");

`endif

>>> hw/rtl/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Types and constants of the column standard scaler.
// ----------------------------------------------------------------------------
package css_pkg;

	localparam int VAL_W  = 24;
	localparam int CNT_W  = 16;
	localparam int SUM_W  = 40;
	localparam int SQ_W   = 64;
	localparam int DIV_W  = 64;
	localparam int ROOT_W = 32;
	localparam int STEP_W = 6;
	localparam int CFG_W  = 7;
	localparam int ACC_W  = CNT_W + SUM_W + SQ_W;
	localparam int STAT_W = 2 * VAL_W;

	typedef enum logic [1:0] {
		REQ_ACC  = 2'd0,
		REQ_FIN  = 2'd1,
		REQ_TR   = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_COL = 3'd1,
		ST_NOT_FIT = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_SAT     = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_READ, S_DECODE, S_ACC_MUL, S_ACC_WR,
		S_MEAN_INIT, S_MEAN_DIV, S_MEAN_SAVE, S_EX2_DIV, S_EX2_SAVE,
		S_VAR, S_SQRT, S_FIN_WR, S_TR_INIT, S_TR_DIV, S_TR_SAVE, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_READ, OP_EARLY, OP_ACC_MUL, OP_ACC_WR,
		OP_MEAN_INIT, OP_DIV_STEP, OP_MEAN_SAVE, OP_EX2_SAVE, OP_VAR,
		OP_SQRT_STEP, OP_FIN_WR, OP_TR_INIT, OP_TR_SAVE, OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		req_t req;
		logic early;    // item ends without arithmetic
		logic out_free; // output register can take a result
	} dp_sts_t;

endpackage

>>> hw/rtl/css_ram.sv
// ----------------------------------------------------------------------------
// css_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module css_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/css_ctrl.sv
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencer: walks one transaction through read, arithmetic and write-back.
// ----------------------------------------------------------------------------
module css_ctrl import css_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t              state_q, state_d;
	logic [STEP_W-1:0]   step_q;
	logic                div_last, sqrt_last, stepping;

	assign div_last  = (step_q == STEP_W'(DIV_W - 1));
	assign sqrt_last = (step_q == STEP_W'(ROOT_W - 1));
	assign stepping  = (state_q == S_MEAN_DIV) || (state_q == S_EX2_DIV) ||
		(state_q == S_TR_DIV) || (state_q == S_SQRT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (in_valid) state_d = S_READ;
			S_READ:      state_d = S_DECODE;
			S_DECODE: begin
				if (sts.early) begin
					state_d = S_DONE;
				end else begin
					case (sts.req)
						REQ_ACC: state_d = S_ACC_MUL;
						REQ_FIN: state_d = S_MEAN_INIT;
						REQ_TR:  state_d = S_TR_INIT;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_ACC_MUL:   state_d = S_ACC_WR;
			S_ACC_WR:    state_d = S_DONE;
			S_MEAN_INIT: state_d = S_MEAN_DIV;
			S_MEAN_DIV:  if (div_last) state_d = S_MEAN_SAVE;
			S_MEAN_SAVE: state_d = S_EX2_DIV;
			S_EX2_DIV:   if (div_last) state_d = S_EX2_SAVE;
			S_EX2_SAVE:  state_d = S_VAR;
			S_VAR:       state_d = S_SQRT;
			S_SQRT:      if (sqrt_last) state_d = S_FIN_WR;
			S_FIN_WR:    state_d = S_DONE;
			S_TR_INIT:   state_d = S_TR_DIV;
			S_TR_DIV:    if (div_last) state_d = S_TR_SAVE;
			S_TR_SAVE:   state_d = S_DONE;
			S_DONE:      if (sts.out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE:      if (in_valid) cmd.op = OP_LOAD;
			S_READ:      cmd.op = OP_READ;
			S_DECODE:    if (sts.early) cmd.op = OP_EARLY;
			S_ACC_MUL:   cmd.op = OP_ACC_MUL;
			S_ACC_WR:    cmd.op = OP_ACC_WR;
			S_MEAN_INIT: cmd.op = OP_MEAN_INIT;
			S_MEAN_DIV:  cmd.op = OP_DIV_STEP;
			S_MEAN_SAVE: cmd.op = OP_MEAN_SAVE;
			S_EX2_DIV:   cmd.op = OP_DIV_STEP;
			S_EX2_SAVE:  cmd.op = OP_EX2_SAVE;
			S_VAR:       cmd.op = OP_VAR;
			S_SQRT:      cmd.op = OP_SQRT_STEP;
			S_FIN_WR:    cmd.op = OP_FIN_WR;
			S_TR_INIT:   cmd.op = OP_TR_INIT;
			S_TR_DIV:    cmd.op = OP_DIV_STEP;
			S_TR_SAVE:   cmd.op = OP_TR_SAVE;
			S_DONE:      if (sts.out_free) cmd.op = OP_OUT_LOAD;
			default:     cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= stepping ? step_q + STEP_W'(1) : '0;
		end
	end

endmodule

>>> hw/rtl/css_dp.sv
// ----------------------------------------------------------------------------
// css_dp
// Datapath: column memories, shared restoring divider, square root unit,
// result and output registers.
// ----------------------------------------------------------------------------
module css_dp import css_pkg::*; #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 65535
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_sts_t                 sts,
	input  logic [1:0]              req_type,
	input  logic [5:0]              column,
	input  logic signed [VAL_W-1:0] sample_value,
	input  logic                    cfg_we,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [2:0]              status,
	output logic signed [VAL_W-1:0] scaled_or_mean,
	output logic [VAL_W-1:0]        deviation
);

	localparam int AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int LIM_W = 11;
	localparam logic [LIM_W-1:0] MAXC = LIM_W'(MAX_COLUMNS);
	localparam logic [VAL_W-1:0] SAT_POS = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] SAT_NEG = {1'b1, {(VAL_W-1){1'b0}}};

	// transaction registers
	req_t                    req_q;
	logic [5:0]              col_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CFG_W-1:0]        cfg_q;
	logic                    bad_q, accv_q, fit_q;
	logic [AW-1:0]           addr;

	// valid bits stand in for the all-zero reset of the memories
	logic acc_vld_q [MAX_COLUMNS];
	logic fitted_q  [MAX_COLUMNS];

	logic [ACC_W-1:0]  acc_rd, acc_wd;
	logic [STAT_W-1:0] stat_rd;
	logic [CNT_W-1:0]  cnt;
	logic [SUM_W-1:0]  sum;
	logic [SQ_W-1:0]   sumsq;
	logic signed [VAL_W-1:0] mean_rd;
	logic [VAL_W-1:0]  sd_rd;

	// arithmetic registers
	logic [47:0]             prod_q;
	logic signed [47:0]      sq_full;
	logic signed [VAL_W-1:0] mean_q;
	logic signed [47:0]      msq_full;
	logic [47:0]             msq_q;
	logic [SQ_W-1:0]         ex2_q;
	logic                    neg_q;

	logic [VAL_W-1:0]  div_rem_q, div_d_q;
	logic [DIV_W-1:0]  div_quo_q;
	logic [VAL_W:0]    div_t;
	logic              div_ge;

	logic [SQ_W-1:0]     sq_v_q;
	logic [ROOT_W+1:0]   sq_rem_q;
	logic [ROOT_W-1:0]   sq_root_q;
	logic [ROOT_W+3:0]   sq_t, sq_trial;
	logic                sq_ge;

	logic [LIM_W-1:0]  lim, cfg_ext;
	logic [SUM_W-1:0]  sum_mag;
	logic signed [VAL_W:0] diff;
	logic [VAL_W:0]    diff_mag;
	logic [VAL_W-1:0]  sd_sat;
	logic [SQ_W-1:0]   var_w;
	logic [VAL_W-1:0]  tr_res;
	status_t           early_code;
	logic              sat, empty, early;

	// result and output registers
	status_t           res_status_q, out_status_q;
	logic [VAL_W-1:0]  res_scaled_q, res_dev_q, out_scaled_q, out_dev_q;
	logic              out_valid_q;

	assign addr = AW'(col_q);

	css_ram #(.WIDTH(ACC_W), .DEPTH(MAX_COLUMNS)) u_acc_ram (
		.clk   (clk),
		.we    (cmd.op == OP_ACC_WR),
		.waddr (addr),
		.wdata (acc_wd),
		.re    (cmd.op == OP_READ),
		.raddr (addr),
		.rdata (acc_rd)
	);

	css_ram #(.WIDTH(STAT_W), .DEPTH(MAX_COLUMNS)) u_stat_ram (
		.clk   (clk),
		.we    (cmd.op == OP_FIN_WR),
		.waddr (addr),
		.wdata ({mean_q, sd_sat}),
		.re    (cmd.op == OP_READ),
		.raddr (addr),
		.rdata (stat_rd)
	);

	always_comb begin
		cnt     = accv_q ? acc_rd[ACC_W-1 -: CNT_W] : '0;
		sum     = accv_q ? acc_rd[SQ_W +: SUM_W] : '0;
		sumsq   = accv_q ? acc_rd[SQ_W-1:0] : '0;
		mean_rd = stat_rd[STAT_W-1 -: VAL_W];
		sd_rd   = stat_rd[VAL_W-1:0];
		acc_wd  = {cnt + CNT_W'(1), sum + SUM_W'(val_q), sumsq + SQ_W'(prod_q)};

		cfg_ext = LIM_W'(cfg_q);
		lim     = (cfg_ext < MAXC) ? cfg_ext : MAXC;

		sat   = (cnt >= CNT_W'(MAX_ROWS));
		empty = (cnt == '0);
		early = 1'b0;
		early_code = ST_OK;
		if (req_q == REQ_NONE) begin
			early = 1'b1;
		end else if (bad_q) begin
			early = 1'b1;
			early_code = ST_BAD_COL;
		end else begin
			case (req_q)
				REQ_ACC: if (sat) begin
					early = 1'b1;
					early_code = ST_SAT;
				end
				REQ_FIN: if (empty) begin
					early = 1'b1;
					early_code = ST_EMPTY;
				end
				REQ_TR: begin
					if (!fit_q) begin
						early = 1'b1;
						early_code = ST_NOT_FIT;
					end else if (sd_rd == '0) begin
						early = 1'b1;
					end
				end
				default: early = 1'b1;
			endcase
		end

		sq_full  = val_q * val_q;
		msq_full = mean_q * mean_q;
		sum_mag  = sum[SUM_W-1] ? -sum : sum;
		diff     = (VAL_W+1)'(val_q) - (VAL_W+1)'(mean_rd);
		diff_mag = diff[VAL_W] ? -diff : diff;

		// one restoring division step
		div_t  = {div_rem_q, div_quo_q[DIV_W-1]};
		div_ge = (div_t >= {1'b0, div_d_q});

		// one square root step, two radicand bits at a time
		sq_t     = {sq_rem_q, sq_v_q[SQ_W-1 -: 2]};
		sq_trial = {2'b00, sq_root_q, 2'b01};
		sq_ge    = (sq_t >= sq_trial);

		sd_sat = (|sq_root_q[ROOT_W-1:VAL_W]) ? {VAL_W{1'b1}} : sq_root_q[VAL_W-1:0];
		var_w  = (ex2_q > SQ_W'(msq_q)) ? ex2_q - SQ_W'(msq_q) : '0;

		if (neg_q) begin
			tr_res = (div_quo_q > DIV_W'(SAT_NEG)) ? SAT_NEG : -div_quo_q[VAL_W-1:0];
		end else begin
			tr_res = (div_quo_q > DIV_W'(SAT_POS)) ? SAT_POS : div_quo_q[VAL_W-1:0];
		end
	end

	assign sts.req      = req_q;
	assign sts.early    = early;
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CFG_W'(64);
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_COLUMNS; i++) begin
				acc_vld_q[i] <= 1'b0;
				fitted_q[i]  <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (cmd.op == OP_OUT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.op == OP_ACC_WR) begin
				acc_vld_q[addr] <= 1'b1;
			end
			if (cmd.op == OP_FIN_WR) begin
				acc_vld_q[addr] <= 1'b0;
				fitted_q[addr]  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				req_q <= req_t'(req_type);
				col_q <= column;
				val_q <= sample_value;
			end
			OP_READ: begin
				bad_q  <= (LIM_W'(col_q) >= lim);
				accv_q <= acc_vld_q[addr];
				fit_q  <= fitted_q[addr];
			end
			OP_EARLY: begin
				res_status_q <= early_code;
				res_scaled_q <= '0;
				res_dev_q    <= '0;
			end
			OP_ACC_MUL: prod_q <= 48'(sq_full);
			OP_ACC_WR: begin
				res_status_q <= ST_OK;
				res_scaled_q <= '0;
				res_dev_q    <= '0;
			end
			OP_MEAN_INIT: begin
				neg_q     <= sum[SUM_W-1];
				div_quo_q <= DIV_W'(sum_mag);
				div_d_q   <= VAL_W'(cnt);
				div_rem_q <= '0;
			end
			OP_DIV_STEP: begin
				div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
				div_rem_q <= div_ge ? VAL_W'(div_t - {1'b0, div_d_q}) : div_t[VAL_W-1:0];
			end
			OP_MEAN_SAVE: begin
				mean_q    <= neg_q ? -div_quo_q[VAL_W-1:0] : div_quo_q[VAL_W-1:0];
				div_quo_q <= sumsq;
				div_d_q   <= VAL_W'(cnt);
				div_rem_q <= '0;
			end
			OP_EX2_SAVE: begin
				ex2_q <= div_quo_q;
				msq_q <= 48'(msq_full);
			end
			OP_VAR: begin
				sq_v_q    <= var_w;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			OP_SQRT_STEP: begin
				sq_v_q    <= {sq_v_q[SQ_W-3:0], 2'b00};
				sq_rem_q  <= sq_ge ? (ROOT_W+2)'(sq_t - sq_trial) : (ROOT_W+2)'(sq_t);
				sq_root_q <= {sq_root_q[ROOT_W-2:0], sq_ge};
			end
			OP_FIN_WR: begin
				res_status_q <= ST_OK;
				res_scaled_q <= mean_q;
				res_dev_q    <= sd_sat;
			end
			OP_TR_INIT: begin
				neg_q     <= diff[VAL_W];
				div_quo_q <= {{(DIV_W-VAL_W-17){1'b0}}, diff_mag, 16'h0000};
				div_d_q   <= sd_rd;
				div_rem_q <= '0;
			end
			OP_TR_SAVE: begin
				res_status_q <= ST_OK;
				res_scaled_q <= tr_res;
				res_dev_q    <= sd_rd;
			end
			OP_OUT_LOAD: begin
				out_status_q <= res_status_q;
				out_scaled_q <= res_scaled_q;
				out_dev_q    <= res_dev_q;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign scaled_or_mean = out_scaled_q;
	assign deviation      = out_dev_q;

endmodule

>>> hw/rtl/column_standard_scaler.sv
// ----------------------------------------------------------------------------
// column_standard_scaler
// Per-column z-score scaler, signed Q8.16: accumulate, finalize, transform.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with req_type, column, sample_value.
// Output channel: out_valid/out_stall with status, scaled_or_mean, deviation.
// Every input transaction gives exactly one output transaction, in order.
// One transaction is worked on at a time; in_stall is high from acceptance
// until its result is placed in the output register.
// Work per transaction, done by the shared one-bit-per-cycle divider
// (64 steps) and the two-bit-per-cycle square root (32 steps):
//   bad column, unused request, error cases, zero deviation: no arithmetic
//   accumulate: one multiply and a write-back
//   transform: one division
//   finalize: two divisions and one square root
// The next transaction can be accepted while the previous result is still
// stalled in the output register; a result that is stalled holds until
// taken.
// Reset clears the statistics of all columns and sets columns_in_use to 64.
// cfg_we/cfg_data write columns_in_use; write only while idle.
// ----------------------------------------------------------------------------
module column_standard_scaler import css_pkg::*; #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 65535
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              req_type,
	input  logic [5:0]              column,
	input  logic signed [VAL_W-1:0] sample_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [2:0]              status,
	output logic signed [VAL_W-1:0] scaled_or_mean,
	output logic [VAL_W-1:0]        deviation,
	input  logic                    cfg_we,
	input  logic [CFG_W-1:0]        cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	css_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	css_dp #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req_type),
		.column         (column),
		.sample_value   (sample_value),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.scaled_or_mean (scaled_or_mean),
		.deviation      (deviation)
	);

endmodule

>>> hw/rtl/css_checker.sv
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks of the scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "column_standard_scaler_assert.svh"

module css_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [23:0] scaled_or_mean,
	input logic [23:0] deviation
);

	// a stalled result holds
	`CSS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(scaled_or_mean) && $stable(deviation))

	// one transaction at a time: busy right after acceptance
	`CSS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// status code stays within the defined set
	`CSS_ASSERT_IMP(a_status_range, out_valid, status <= 3'd4)

	// error results carry zero fields
	`CSS_ASSERT_IMP(a_err_zero, out_valid && (status != 3'd0), (scaled_or_mean == 24'd0) && (deviation == 24'd0))

endmodule

bind column_standard_scaler css_checker u_css_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.scaled_or_mean (scaled_or_mean),
	.deviation      (deviation)
);
